@@ hdl/button_debounce_longpress_events_assert.svh @@
// assertion macros for the button debounce block
`ifndef BUTTON_DEBOUNCE_LONGPRESS_EVENTS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_EVENTS_ASSERT_SVH

// condition holds on every clock edge out of reset
`define BDL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds on the same edge as the antecedent
`define BDL_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds on the edge after the antecedent
`define BDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bdl_pkg.sv @@
// shared types and constants of the button debounce block
`default_nettype none

package bdl_pkg;

	typedef enum logic [2:0] {
		EV_DOWN        = 3'd0,
		EV_UP          = 3'd1,
		EV_CLICK       = 3'd2,
		EV_LONGPRESS   = 3'd3,
		EV_HOLD        = 3'd4,
		EV_UNLONGPRESS = 3'd5
	} ev_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LONGPRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;

	localparam logic [15:0] RESET_LONGPRESS_MS = 16'd1000;
	localparam logic [7:0]  RESET_DEBOUNCE_MS  = 8'd50;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// one or two events produced by a single poll
	typedef struct packed {
		logic two;
		ev_t  ev0;
		ev_t  ev1;
	} q_entry_t;

endpackage

`default_nettype wire

@@ hdl/bdl_front.sv @@
// poll front end: debounce, press tracking and event classification
`default_nettype none

module bdl_front #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            level,
	input  wire logic [31:0]                     now_ms,
	input  wire logic                            cfg_wen,
	input  wire logic [bdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bdl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            q_full,
	output      logic                            q_push,
	output      bdl_pkg::q_entry_t               q_entry
);

	logic [15:0]          longpress_q;
	logic [7:0]           debounce_q;
	logic                 prev_level_q;
	logic [TIME_BITS-1:0] stable_since_q;
	logic [TIME_BITS-1:0] press_start_q;
	logic                 tracked_q;
	logic                 long_q;

	logic                 accept;
	logic [TIME_BITS-1:0] now_w;
	logic [TIME_BITS-1:0] stable_age;
	logic [TIME_BITS-1:0] press_age;
	logic                 changed;
	logic                 settled;
	logic                 reach;
	logic                 has_ev;
	logic                 set_track;
	logic                 clr_track;
	logic                 set_long;

	assign accept     = push && !q_full;
	assign now_w      = TIME_BITS'(now_ms);
	assign stable_age = now_w - stable_since_q;
	assign press_age  = now_w - press_start_q;
	assign changed    = level ^ prev_level_q;
	assign settled    = !changed && (stable_age > TIME_BITS'(debounce_q));
	assign reach      = press_age >= TIME_BITS'(longpress_q);

	always_comb begin
		has_ev        = 1'b0;
		set_track     = 1'b0;
		clr_track     = 1'b0;
		set_long      = 1'b0;
		q_entry.two   = 1'b0;
		q_entry.ev0   = bdl_pkg::EV_DOWN;
		q_entry.ev1   = bdl_pkg::EV_HOLD;
		if (settled && level) begin
			if (!tracked_q) begin
				has_ev    = 1'b1;
				set_track = 1'b1;
			end else if (!long_q && reach) begin
				has_ev      = 1'b1;
				set_long    = 1'b1;
				q_entry.two = 1'b1;
				q_entry.ev0 = bdl_pkg::EV_LONGPRESS;
			end else if (long_q) begin
				has_ev      = 1'b1;
				q_entry.ev0 = bdl_pkg::EV_HOLD;
			end
		end else if (settled && tracked_q) begin
			has_ev    = 1'b1;
			clr_track = 1'b1;
			if (long_q) begin
				q_entry.ev0 = bdl_pkg::EV_UNLONGPRESS;
			end else begin
				q_entry.two = 1'b1;
				q_entry.ev0 = bdl_pkg::EV_UP;
				q_entry.ev1 = bdl_pkg::EV_CLICK;
			end
		end
	end

	assign q_push = accept && has_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			longpress_q <= bdl_pkg::RESET_LONGPRESS_MS;
			debounce_q  <= bdl_pkg::RESET_DEBOUNCE_MS;
		end else if (cfg_wen) begin
			if (cfg_index == bdl_pkg::REG_LONGPRESS) begin
				longpress_q <= cfg_data[15:0];
			end else if (cfg_index == bdl_pkg::REG_DEBOUNCE) begin
				debounce_q <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q   <= 1'b0;
			stable_since_q <= '0;
			press_start_q  <= '0;
			tracked_q      <= 1'b0;
			long_q         <= 1'b0;
		end else if (accept) begin
			prev_level_q <= level;
			if (changed) begin
				stable_since_q <= now_w;
			end
			if (set_track) begin
				tracked_q     <= 1'b1;
				press_start_q <= now_w;
			end
			if (clr_track) begin
				tracked_q <= 1'b0;
				long_q    <= 1'b0;
			end
			if (set_long) begin
				long_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/bdl_queue.sv @@
// short queue of classified polls between front and back
`default_nettype none

module bdl_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bdl_pkg::q_entry_t  wr_entry,
	input  wire logic               pop,
	output      logic               full,
	output      logic               q_empty,
	output      bdl_pkg::q_entry_t  head
);

	bdl_pkg::q_entry_t                  mem_q [bdl_pkg::Q_DEPTH];
	logic [bdl_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [bdl_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [bdl_pkg::Q_CNT_W-1:0]        count_q;

	assign full    = count_q == bdl_pkg::Q_CNT_W'(bdl_pkg::Q_DEPTH);
	assign q_empty = count_q == '0;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bdl_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bdl_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bdl_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bdl_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/bdl_back.sv @@
// event back end: splits each queued poll into single result requests
`default_nettype none

module bdl_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire bdl_pkg::q_entry_t  q_head,
	output      logic               q_pop,
	input  wire logic               pop,
	output      logic               empty,
	output      logic [2:0]         event_res,
	output      logic               last
);

	bdl_pkg::q_entry_t cur_q;
	logic              cur_valid_q;
	logic              half_q;

	logic done;
	logic adv;
	logic load;

	assign done  = cur_valid_q && pop && (!cur_q.two || half_q);
	assign adv   = cur_valid_q && pop && cur_q.two && !half_q;
	assign load  = (!cur_valid_q || done) && !q_empty;
	assign q_pop = load;

	assign empty     = !cur_valid_q;
	assign event_res = half_q ? cur_q.ev1 : cur_q.ev0;
	assign last      = !cur_q.two || half_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			half_q      <= 1'b0;
		end else if (done) begin
			cur_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (adv) begin
			half_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ hdl/button_debounce_longpress_events.sv @@
// Button debouncer with long-press events. Each accepted poll (level plus a
// millisecond timestamp) is classified in the cycle it is accepted, and its
// zero, one or two events go into a four-entry queue; a back end hands them
// out one per cycle while pop is high, the oldest first, with last set on the
// final event of a poll. A poll is accepted every cycle while full is low;
// full rises only when four polls with events wait behind the event being
// delivered. The first event of a poll passes through the queue and the
// back end's current-entry register before it appears, and a poll with two
// events holds the result side until both are popped. Time differences are
// taken modulo 2^TIME_BITS; configuration writes take effect on the next poll.
`default_nettype none
`include "button_debounce_longpress_events_assert.svh"

module button_debounce_longpress_events #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output      logic                            full,
	input  wire logic                            level,
	input  wire logic [31:0]                     now_ms,
	output      logic                            empty,
	input  wire logic                            pop,
	output      logic [2:0]                      event_res,
	output      logic                            last,
	input  wire logic                            cfg_wen,
	input  wire logic [bdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bdl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	bdl_pkg::q_entry_t q_entry;
	bdl_pkg::q_entry_t q_head;

	bdl_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.level     (level),
		.now_ms    (now_ms),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	bdl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_entry),
		.pop      (q_pop),
		.full     (full),
		.q_empty  (q_empty),
		.head     (q_head)
	);

	bdl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.event_res (event_res),
		.last      (last)
	);

	// only up and longpress are ever followed by a second event
	`BDL_ASSERT_IMPLY(a_first_kind, !empty && !last,
		event_res == bdl_pkg::EV_UP || event_res == bdl_pkg::EV_LONGPRESS,
		"unexpected event kind before the end of a poll")

	// the second event of a poll follows at once
	`BDL_ASSERT_NEXT(a_pair_follows, !empty && pop && !last, !empty && last,
		"second event of a poll missing")

	// back end is loaded whenever the queue fills
	`BDL_ASSERT_IMPLY(a_full_busy, full, !empty,
		"queue full while result side idle")

endmodule

`default_nettype wire
